// ===== hdl/lzw_pkg.sv =====
// ----------------------------------------------------------------------------
// lzw_pkg
// Shared widths, constants and types of the LZW encoder.
// ----------------------------------------------------------------------------
package lzw_pkg;

    localparam int CODE_BITS  = 12;
    localparam int HASH_BITS  = 13;
    localparam int HASH_SLOTS = 1 << HASH_BITS;
    localparam int SYM_BITS   = 9;
    localparam int OUT_BITS   = 12;
    localparam int EPOCH_BITS = 8;

    localparam logic [CODE_BITS:0] FIRST_FREE = (CODE_BITS + 1)'(268);
    localparam logic [31:0]        HASH_MUL_P = 32'h0000_9E37;
    localparam logic [31:0]        HASH_MUL_S = 32'h0000_45D9;

    typedef logic [CODE_BITS-1:0]  code_t;
    typedef logic [SYM_BITS-1:0]   sym_t;
    typedef logic [HASH_BITS-1:0]  slot_t;
    typedef logic [EPOCH_BITS-1:0] epoch_t;

    // An entry belongs to the open message only when its epoch matches.
    typedef struct packed {
        epoch_t epoch;
        code_t  key_prefix;
        sym_t   key_sym;
        code_t  code;
    } entry_t;

    typedef struct packed {
        logic   en;
        slot_t  addr;
        entry_t data;
    } dict_wr_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_PROBE,
        ST_EMIT_MID,
        ST_EMIT_LAST
    } state_t;

endpackage

// ===== hdl/lzw_encoder.sv =====
// ----------------------------------------------------------------------------
// lzw_encoder
// LZW encoder with a linearly probed hash dictionary.
// ----------------------------------------------------------------------------
// Input stream: s_tdata[8:0] carries a single-character symbol code, s_tlast
// marks the last symbol of a message. Output stream: m_tdata[11:0] carries an
// emitted code, m_tlast marks the final code of a message.
// The first symbol of a message opens the prefix without a probe. Every later
// symbol is accepted, then probes the dictionary until a probed slot decides,
// one more probe per collision. Each emitted code is then loaded into the
// output register. The probing runs through the single dictionary read port,
// which the probe loop uses once a cycle.
// The output register stays loaded until taken; a stalled receiver holds the
// block only when a new code must be loaded while the register is still full.
// Dictionary entries carry a message epoch, so ending a message clears the
// dictionary at once. After reset, and after every 255th message of two or
// more symbols, a clearing pass sweeps all 8192 memory slots; s_tready is
// low during it.
// Reset is synchronous, active low.
// ----------------------------------------------------------------------------
module lzw_encoder
    import lzw_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // [8:0] symbol_code, [15:9] zero
    input  logic        s_tlast,   // end_of_message
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // [11:0] out_code, [15:12] zero
    output logic        m_tlast    // out_last
);

    state_t         state_reg, state_next;
    sym_t           sym_reg, sym_next;
    logic           eom_reg, eom_next;
    code_t          prefix_reg, prefix_next;
    logic           prefix_valid_reg, prefix_valid_next;
    logic [CODE_BITS:0] free_code_reg, free_code_next;
    epoch_t         epoch_reg, epoch_next;
    slot_t          slot_reg, slot_next;
    slot_t          probe_cnt_reg, probe_cnt_next;
    slot_t          clr_addr_reg, clr_addr_next;
    logic           clr_pending_reg, clr_pending_next;
    code_t          pend_code_reg, pend_code_next;
    logic           m_valid_reg, m_valid_next;
    logic [OUT_BITS-1:0] m_code_reg, m_code_next;
    logic           m_last_reg, m_last_next;

    sym_t     in_sym;
    slot_t    hash_slot;
    entry_t   rd_data;
    dict_wr_t wr;
    logic     entry_live;
    logic     hit;
    logic     out_free;

    assign in_sym   = s_tdata[SYM_BITS-1:0];
    assign s_tready = (state_reg == ST_IDLE);
    assign out_free = !m_valid_reg || m_tready;

    lzw_hash u_hash (
        .prefix (prefix_reg),
        .symbol (in_sym),
        .slot   (hash_slot)
    );

    lzw_dict u_dict (
        .aclk    (aclk),
        .rd_addr (slot_next),
        .rd_data (rd_data),
        .wr      (wr)
    );

    assign entry_live = (rd_data.epoch == epoch_reg);
    assign hit = entry_live && (rd_data.key_prefix == prefix_reg) &&
                 (rd_data.key_sym == sym_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg        <= ST_CLEAR;
            prefix_reg       <= '0;
            prefix_valid_reg <= 1'b0;
            free_code_reg    <= FIRST_FREE;
            epoch_reg        <= epoch_t'(1);
            clr_addr_reg     <= '0;
            clr_pending_reg  <= 1'b0;
            m_valid_reg      <= 1'b0;
        end else begin
            state_reg        <= state_next;
            prefix_reg       <= prefix_next;
            prefix_valid_reg <= prefix_valid_next;
            free_code_reg    <= free_code_next;
            epoch_reg        <= epoch_next;
            clr_addr_reg     <= clr_addr_next;
            clr_pending_reg  <= clr_pending_next;
            m_valid_reg      <= m_valid_next;
        end
        sym_reg       <= sym_next;
        eom_reg       <= eom_next;
        slot_reg      <= slot_next;
        probe_cnt_reg <= probe_cnt_next;
        pend_code_reg <= pend_code_next;
        m_code_reg    <= m_code_next;
        m_last_reg    <= m_last_next;
    end

    always_comb begin
        state_next        = state_reg;
        sym_next          = sym_reg;
        eom_next          = eom_reg;
        prefix_next       = prefix_reg;
        prefix_valid_next = prefix_valid_reg;
        free_code_next    = free_code_reg;
        epoch_next        = epoch_reg;
        slot_next         = slot_reg;
        probe_cnt_next    = probe_cnt_reg;
        clr_addr_next     = clr_addr_reg;
        clr_pending_next  = clr_pending_reg;
        pend_code_next    = pend_code_reg;
        m_valid_next      = m_valid_reg;
        m_code_next       = m_code_reg;
        m_last_next       = m_last_reg;
        wr                = '0;

        if (m_valid_reg && m_tready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            ST_CLEAR: begin
                wr.en         = 1'b1;
                wr.addr       = clr_addr_reg;
                wr.data       = '0;
                clr_addr_next = clr_addr_reg + 1'b1;
                if (clr_addr_reg == '1) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (s_tvalid) begin
                    sym_next = in_sym;
                    eom_next = s_tlast;
                    if (!prefix_valid_reg) begin
                        // first symbol only opens the prefix
                        prefix_next = CODE_BITS'(in_sym);
                        if (s_tlast) begin
                            state_next = ST_EMIT_LAST;
                        end else begin
                            prefix_valid_next = 1'b1;
                        end
                    end else begin
                        slot_next      = hash_slot;
                        probe_cnt_next = '0;
                        state_next     = ST_PROBE;
                    end
                end
            end
            ST_PROBE: begin
                if (hit) begin
                    prefix_next = rd_data.code;
                    state_next  = eom_reg ? ST_EMIT_LAST : ST_IDLE;
                end else if (!entry_live || probe_cnt_reg == '1) begin
                    // empty slot, or the whole table probed without room
                    pend_code_next = prefix_reg;
                    if (!free_code_reg[CODE_BITS]) begin
                        if (!entry_live) begin
                            wr.en              = 1'b1;
                            wr.addr            = slot_reg;
                            wr.data.epoch      = epoch_reg;
                            wr.data.key_prefix = prefix_reg;
                            wr.data.key_sym    = sym_reg;
                            wr.data.code       = free_code_reg[CODE_BITS-1:0];
                        end
                        free_code_next = free_code_reg + 1'b1;
                    end
                    prefix_next = CODE_BITS'(sym_reg);
                    state_next  = ST_EMIT_MID;
                end else begin
                    slot_next      = slot_reg + 1'b1;
                    probe_cnt_next = probe_cnt_reg + 1'b1;
                end
                if ((hit || !entry_live || probe_cnt_reg == '1) && eom_reg) begin
                    // close the message: new epoch empties the dictionary
                    prefix_valid_next = 1'b0;
                    free_code_next    = FIRST_FREE;
                    if (epoch_reg == '1) begin
                        epoch_next       = epoch_t'(1);
                        clr_pending_next = 1'b1;
                    end else begin
                        epoch_next = epoch_reg + 1'b1;
                    end
                end
            end
            ST_EMIT_MID: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_code_next  = pend_code_reg[OUT_BITS-1:0];
                    m_last_next  = 1'b0;
                    state_next   = eom_reg ? ST_EMIT_LAST : ST_IDLE;
                end
            end
            ST_EMIT_LAST: begin
                if (out_free) begin
                    m_valid_next     = 1'b1;
                    m_code_next      = prefix_reg[OUT_BITS-1:0];
                    m_last_next      = 1'b1;
                    clr_pending_next = 1'b0;
                    clr_addr_next    = '0;
                    state_next       = clr_pending_reg ? ST_CLEAR : ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {{(16 - OUT_BITS){1'b0}}, m_code_reg};
    assign m_tlast  = m_last_reg;

endmodule

// ===== hdl/lzw_hash.sv =====
// ----------------------------------------------------------------------------
// lzw_hash
// Multiplicative hash of a (prefix, symbol) pair onto a dictionary slot.
// ----------------------------------------------------------------------------
module lzw_hash
    import lzw_pkg::*;
(
    input  code_t prefix,
    input  sym_t  symbol,
    output slot_t slot
);

    logic [31:0] prod_p;
    logic [31:0] prod_s;

    assign prod_p = 32'(prefix) * HASH_MUL_P;
    assign prod_s = 32'(symbol) * HASH_MUL_S;

    // slot count is a power of two, so the modulo is the low bits
    assign slot = prod_p[HASH_BITS-1:0] ^ prod_s[HASH_BITS-1:0];

endmodule

// ===== hdl/lzw_dict.sv =====
// ----------------------------------------------------------------------------
// lzw_dict
// Dictionary memory: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module lzw_dict
    import lzw_pkg::*;
(
    input  logic     aclk,
    input  slot_t    rd_addr,
    output entry_t   rd_data,
    input  dict_wr_t wr
);

    entry_t mem [HASH_SLOTS];
    entry_t rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr.en) begin
            mem[wr.addr] <= wr.data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== dv/tb_lzw_encoder.sv =====
// ----------------------------------------------------------------------------
// tb_lzw_encoder
// Self-checking bench for the LZW encoder stream block.
// ----------------------------------------------------------------------------
// A behavioral LZW coder in the bench tracks the prefix, the next free code and
// a linearly probed hash dictionary. It turns each accepted symbol into the
// codes the block should emit. Every emitted code is compared in order with
// that list.
// The named tests cover the following:
//   - short directed messages;
//   - a few hundred two-symbol messages that wrap the dictionary epoch;
//   - a long receiver stall, and a sender pause until the block is drained;
//   - random messages under three idling profiles.
// ----------------------------------------------------------------------------
module tb_lzw_encoder;
    import lzw_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned FIRST_CODE  = 268;
    localparam int unsigned CODE_LIMIT  = 1 << CODE_BITS;
    localparam int unsigned HASH_P      = 32'h0000_9E37;
    localparam int unsigned HASH_S      = 32'h0000_45D9;
    localparam int          STALL_LIMIT = 50000;   // covers the clearing sweep of all dictionary slots
    localparam int          RX_HOLD     = 300;

    typedef struct {
        code_t code;
        bit    last;
    } code_word_t;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [15:0] s_tdata  = '0;   // [8:0] symbol_code, [15:9] zero
    logic        s_tlast  = 1'b0; // end_of_message
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;         // [11:0] out_code, [15:12] zero
    logic        m_tlast;         // out_last

    // encoder state mirrored by the bench
    code_t       dict_prefix [HASH_SLOTS];
    sym_t        dict_sym    [HASH_SLOTS];
    code_t       dict_code   [HASH_SLOTS];
    bit          dict_used   [HASH_SLOTS];
    code_t       cur_prefix;
    bit          prefix_open;
    int unsigned next_code;

    code_word_t  pending_codes[$];

    int tx_idle_pct   = 0;
    int rx_idle_pct   = 0;
    bit rx_hold_start = 1'b0;
    int rx_hold_left  = 0;
    int stall_cycles  = 0;
    int fail_count    = 0;
    int symbols_sent  = 0;
    int messages_sent = 0;
    int codes_checked = 0;

    lzw_encoder uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    always #2 aclk = ~aclk;

    function automatic void log_failure(string msg);
        fail_count++;
        if (fail_count <= 10) begin
            $display("[%0t] MISMATCH: %s", $realtime, msg);
        end
    endfunction

    function automatic void add_expected(code_t code, bit last);
        code_word_t w;
        w.code = code;
        w.last = last;
        pending_codes.insert(pending_codes.size(), w);
    endfunction

    function automatic void clear_dictionary();
        foreach (dict_used[i]) dict_used[i] = 1'b0;
        cur_prefix  = '0;
        prefix_open = 1'b0;
        next_code   = FIRST_CODE;
    endfunction

    function automatic int unsigned slot_hash(int unsigned p, int unsigned s);
        return ((p * HASH_P) ^ (s * HASH_S)) % HASH_SLOTS;
    endfunction

    // Linear probe: hit -> slot of the match; miss -> first empty slot,
    // or HASH_SLOTS when no slot is empty.
    function automatic bit find_slot(code_t p, sym_t s, output int unsigned slot);
        int unsigned idx;
        idx  = slot_hash(32'(p), 32'(s));
        slot = HASH_SLOTS;
        for (int n = 0; n < HASH_SLOTS; n++) begin
            if (!dict_used[idx]) begin
                slot = idx;
                return 1'b0;
            end
            if (dict_prefix[idx] == p && dict_sym[idx] == s) begin
                slot = idx;
                return 1'b1;
            end
            idx = (idx + 1) % HASH_SLOTS;
        end
        return 1'b0;
    endfunction

    function automatic void encode_symbol(sym_t sym, bit eom);
        int unsigned slot;
        if (!prefix_open) begin
            cur_prefix  = code_t'(sym);
            prefix_open = 1'b1;
        end else if (find_slot(cur_prefix, sym, slot)) begin
            cur_prefix = dict_code[slot];
        end else begin
            add_expected(cur_prefix, 1'b0);
            if (next_code < CODE_LIMIT) begin
                if (slot < HASH_SLOTS) begin
                    dict_prefix[slot] = cur_prefix;
                    dict_sym[slot]    = sym;
                    dict_code[slot]   = code_t'(next_code);
                    dict_used[slot]   = 1'b1;
                end
                next_code++;
            end
            cur_prefix = code_t'(sym);
        end
        if (eom) begin
            add_expected(cur_prefix, 1'b1);
            clear_dictionary();
        end
    endfunction

    // Called at a falling edge; returns at the falling edge after the transfer.
    task automatic send_symbol(sym_t sym, bit eom);
        while ($urandom_range(99) < tx_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {7'd0, sym};
        s_tlast  <= eom;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        encode_symbol(sym, eom);
        symbols_sent++;
        if (eom) messages_sent++;
        @(negedge aclk);
    endtask

    task automatic wait_for_codes();
        s_tvalid <= 1'b0;
        do @(negedge aclk); while (pending_codes.size() != 0);
    endtask

    // receiver: random ready, or a long hold when a test asks for one
    always @(negedge aclk) begin
        if (rx_hold_start) begin
            rx_hold_left  = RX_HOLD;
            rx_hold_start = 1'b0;
        end
        if (rx_hold_left > 0) begin
            rx_hold_left--;
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    always @(posedge aclk) begin
        code_word_t want;
        if (aresetn && m_tvalid && m_tready) begin
            codes_checked++;
            if (pending_codes.size() == 0) begin
                log_failure($sformatf("unexpected code: got tdata=%h last=%b",
                                      m_tdata, m_tlast));
            end else begin
                want = pending_codes.pop_front();
                if (m_tdata !== {4'd0, want.code} || m_tlast !== want.last) begin
                    log_failure($sformatf("expected tdata=%h last=%b, got tdata=%h last=%b",
                                          {4'd0, want.code}, want.last, m_tdata, m_tlast));
                end
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            stall_cycles = 0;
        end else begin
            stall_cycles++;
        end
        if (stall_cycles >= STALL_LIMIT) begin
            $display("Timeout: no transfer for %0d cycles", STALL_LIMIT);
            $display("Test completed with failures");
            $finish;
        end
    end

    task automatic test_directed();
        send_symbol(9'd0, 1'b1);      // lone symbol, also last
        send_symbol(9'd511, 1'b1);    // widest symbol
        send_symbol(9'd267, 1'b0);    // run of one symbol: grows into new codes
        send_symbol(9'd267, 1'b0);
        send_symbol(9'd267, 1'b0);
        send_symbol(9'd267, 1'b0);
        send_symbol(9'd267, 1'b1);
        send_symbol(9'd5, 1'b0);      // symbol equal to a dictionary code
        send_symbol(9'd5, 1'b0);
        send_symbol(9'd268, 1'b0);
        send_symbol(9'd5, 1'b0);
        send_symbol(9'd268, 1'b0);
        send_symbol(9'd269, 1'b1);
        send_symbol(9'h155, 1'b0);    // alternating bit patterns
        send_symbol(9'h0AA, 1'b0);
        send_symbol(9'h155, 1'b0);
        send_symbol(9'h0AA, 1'b0);
        send_symbol(9'h1FF, 1'b0);
        send_symbol(9'h000, 1'b1);
    endtask

    // Keys from the same four pairs in every message; stale entries must never match, also
    // across the epoch wrap and the sweep that follows it.
    task automatic test_epoch_wrap();
        for (int m = 0; m < 256; m++) begin
            send_symbol(sym_t'($urandom_range(7, 8)), 1'b0);
            send_symbol(sym_t'($urandom_range(7, 8)), 1'b1);
        end
    endtask

    task automatic test_backpressure();
        rx_hold_start = 1'b1;
        for (int i = 0; i < 24; i++) begin
            send_symbol(sym_t'($urandom_range(20, 23)), i == 23);
        end
        wait_for_codes();
        for (int i = 0; i < 12; i++) begin
            send_symbol(sym_t'($urandom_range(100, 102)), i == 11);
        end
    endtask

    task automatic test_random_messages();
        int   sent;
        int   len;
        int   kind;
        int   base;
        int   plen;
        sym_t pattern[8];
        sym_t sym;
        sent = 0;
        for (int phase = 0; phase < 3; phase++) begin
            tx_idle_pct = (phase == 0) ? 32 : (phase == 1) ? 56 : 0;
            rx_idle_pct = (phase == 0) ? 56 : (phase == 1) ? 32 : 0;
            while (sent < (phase + 1) * 20) begin
                len  = ($urandom_range(9) == 0) ? $urandom_range(12, 20)
                                                : $urandom_range(1, 8);
                kind = $urandom_range(9);
                base = $urandom_range(508);
                plen = $urandom_range(2, 8);
                foreach (pattern[i]) pattern[i] = sym_t'($urandom_range(511));
                for (int i = 0; i < len; i++) begin
                    if (kind < 5) begin
                        sym = sym_t'(base + $urandom_range(3));   // small alphabet
                    end else if (kind < 8) begin
                        sym = pattern[i % plen];                  // repeated phrase
                    end else begin
                        sym = sym_t'($urandom_range(511));        // noise
                    end
                    send_symbol(sym, i == len - 1);
                    sent++;
                end
            end
        end
    endtask

    initial begin
        clear_dictionary();
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        test_directed();
        test_epoch_wrap();
        test_backpressure();
        test_random_messages();

        s_tvalid <= 1'b0;
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        while (pending_codes.size() != 0) @(negedge aclk);
        repeat (32) @(negedge aclk);
        while (pending_codes.size() != 0) begin
            log_failure($sformatf("code %h last %b never arrived",
                                  pending_codes[0].code, pending_codes[0].last));
            void'(pending_codes.pop_front());
        end

        $display("Sent %0d symbols in %0d messages, checked %0d codes, %0d mismatches.",
                 symbols_sent, messages_sent, codes_checked, fail_count);
        $display("Dictionary epoch wrap with sweep, long receiver stall and idling mixes run.");
        if (fail_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
